### hw/rtl/dcq_pkg.sv
// Shared types and constants of the dry-contact qualifier.
package dcq_pkg;

  localparam int CHANNELS    = 8;
  localparam int SAMPLES     = 8;
  localparam int COUNT_WIDTH = 16;
  localparam int CH_W        = $clog2(CHANNELS);
  localparam int TIME_W      = 32;
  localparam int EN_W        = 4;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 2;

  // Input item kinds.
  typedef enum logic [1:0] {
    KIND_SCAN      = 2'd0,
    KIND_CLR_WEB   = 2'd1,
    KIND_CLR_LOCAL = 2'd2
  } kind_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMM_MASK  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd3;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd5000;

  // Per-channel timing state held in the channel memory.
  typedef struct packed {
    logic [TIME_W-1:0]      stamp;
    logic [COUNT_WIDTH-1:0] count;
  } entry_t;

  // Write request into the channel memory.
  typedef struct packed {
    logic            en;
    logic [CH_W-1:0] addr;
    entry_t          data;
  } wr_req_t;

endpackage

### hw/rtl/dcq_chan_ram.sv
// Channel memory holding the low-time stamp and toggle counter of each channel.
module dcq_chan_ram (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    rd_en,
  input  logic [dcq_pkg::CH_W-1:0] rd_addr,
  output dcq_pkg::entry_t         rd_data,
  input  dcq_pkg::wr_req_t        wr
);

  dcq_pkg::entry_t               mem [dcq_pkg::CHANNELS];
  logic [dcq_pkg::CHANNELS-1:0]  written;
  dcq_pkg::entry_t               rd_q;
  logic                          rd_q_written;

  // Storage array with registered read; a read returns the old word on a collision.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Written flags stand in for the all-zero reset of the array.
  always_ff @(posedge clk) begin
    if (rst) begin
      written      <= '0;
      rd_q_written <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_q_written <= written[rd_addr];
      end
    end
  end

  assign rd_data = rd_q_written ? rd_q : '0;

endmodule

### hw/rtl/dry_contact_qualifier_with_toggle_count_top.sv
// Top level of the dry-contact qualifier with rapid-toggle counter.
// One item is taken per clock cycle unless out_ready stalls the output; its result passes
// through the registered memory read, the update stage and the output register.
// The stamp and counter of each channel live in a small synchronous memory that is read
// when an item is taken and written back by a stable scan as it leaves the update stage;
// a back-to-back item on the same channel takes the freshly written word from a bypass
// register. No clearing pass is needed after reset.
module dry_contact_qualifier_with_toggle_count_top (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration port.
  input  logic                              cfg_wr_en,
  input  logic [dcq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dcq_pkg::CFG_DATA_W-1:0]    cfg_data,
  // Input channel.
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        kind,
  input  logic [2:0]                        channel,
  input  logic [7:0]                        samples,
  input  logic [31:0]                       now_ms,
  input  logic                              fast_scan,
  // Output channel.
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              handled,
  output logic                              stable,
  output logic                              level,
  output logic                              new_change,
  output logic                              report_now,
  output logic [15:0]                       toggle_count,
  output logic [7:0]                        all_levels,
  output logic [7:0]                        all_changed
);

  // Configuration registers.
  logic [dcq_pkg::EN_W-1:0]     enabled_channels;
  logic [dcq_pkg::CHANNELS-1:0] fast_read_mask;
  logic [dcq_pkg::CHANNELS-1:0] immediate_mask;
  logic [dcq_pkg::TIME_W-1:0]   toggle_timeout_ms;

  // Flag registers.
  logic [dcq_pkg::CHANNELS-1:0] level_bits, level_bits_next;
  logic [dcq_pkg::CHANNELS-1:0] local_bits, local_bits_next;
  logic [dcq_pkg::CHANNELS-1:0] web_bits, web_bits_next;

  // Update stage.
  logic                          s1_valid;
  logic [1:0]                    s1_kind;
  logic [dcq_pkg::CH_W-1:0]      s1_ch;
  logic [dcq_pkg::SAMPLES-1:0]   s1_samples;
  logic [dcq_pkg::TIME_W-1:0]    s1_now;
  logic                          s1_fast;
  logic                          s1_fwd_hit;
  dcq_pkg::entry_t               s1_fwd_data;

  logic                          in_xfer;
  logic                          s1_adv;
  dcq_pkg::entry_t               ram_rd;
  dcq_pkg::entry_t               cur;
  dcq_pkg::entry_t               upd;
  dcq_pkg::wr_req_t              wr;

  logic                          active;
  logic                          scan_ok;
  logic                          all_one;
  logic                          all_zero;
  logic                          st;
  logic                          old_lvl;
  logic                          lvl_changed;
  logic                          slow;
  logic                          nc;
  logic [dcq_pkg::TIME_W-1:0]    diff;

  assign in_xfer  = in_valid && in_ready;
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled_channels  <= '0;
      fast_read_mask    <= '0;
      immediate_mask    <= '0;
      toggle_timeout_ms <= dcq_pkg::TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        dcq_pkg::CFG_ENABLED:   enabled_channels  <= cfg_data[dcq_pkg::EN_W-1:0];
        dcq_pkg::CFG_FAST_MASK: fast_read_mask    <= cfg_data[dcq_pkg::CHANNELS-1:0];
        dcq_pkg::CFG_IMM_MASK:  immediate_mask    <= cfg_data[dcq_pkg::CHANNELS-1:0];
        dcq_pkg::CFG_TIMEOUT:   toggle_timeout_ms <= cfg_data[dcq_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  dcq_chan_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_xfer),
    .rd_addr (channel),
    .rd_data (ram_rd),
    .wr      (wr)
  );

  // Stage register; the bypass captures a write-back that collides with this read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_kind     <= kind;
      s1_ch       <= channel;
      s1_samples  <= samples;
      s1_now      <= now_ms;
      s1_fast     <= fast_scan;
      s1_fwd_hit  <= wr.en && (wr.addr == channel);
      s1_fwd_data <= wr.data;
    end
  end

  assign cur = s1_fwd_hit ? s1_fwd_data : ram_rd;

  // Qualification and toggle counting for the item in the update stage.
  always_comb begin
    active   = {1'b0, s1_ch} < enabled_channels;
    scan_ok  = active && (s1_kind == dcq_pkg::KIND_SCAN)
               && (fast_read_mask[s1_ch] || !s1_fast);
    all_one  = &s1_samples[dcq_pkg::SAMPLES-1:0];
    all_zero = ~|s1_samples[dcq_pkg::SAMPLES-1:0];
    st       = scan_ok && (all_one || all_zero);
    old_lvl  = level_bits[s1_ch];
    lvl_changed = st && (old_lvl != all_one);
    diff     = s1_now - cur.stamp;
    slow     = diff >= toggle_timeout_ms;
    nc       = lvl_changed && !web_bits[s1_ch];

    upd = cur;
    if (lvl_changed && !all_one) begin
      upd.stamp = s1_now;
    end
    if (st && all_one && slow) begin
      upd.count = '0;
    end else if (lvl_changed && all_one && (cur.count != '1)) begin
      upd.count = cur.count + 1'b1;
    end

    level_bits_next = level_bits;
    local_bits_next = local_bits;
    web_bits_next   = web_bits;
    if (st) begin
      level_bits_next[s1_ch] = all_one;
    end
    if (lvl_changed) begin
      local_bits_next[s1_ch] = 1'b1;
      web_bits_next[s1_ch]   = 1'b1;
    end
    if (active && (s1_kind == dcq_pkg::KIND_CLR_WEB)) begin
      web_bits_next[s1_ch] = 1'b0;
    end
    if (active && (s1_kind == dcq_pkg::KIND_CLR_LOCAL)) begin
      local_bits_next[s1_ch] = 1'b0;
    end

    wr.en   = s1_adv && st;
    wr.addr = s1_ch;
    wr.data = upd;
  end

  // Flags update when the item leaves the update stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      level_bits <= '0;
      local_bits <= '0;
      web_bits   <= '0;
    end else if (s1_adv) begin
      level_bits <= level_bits_next;
      local_bits <= local_bits_next;
      web_bits   <= web_bits_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      handled      <= scan_ok || (active && ((s1_kind == dcq_pkg::KIND_CLR_WEB)
                                          || (s1_kind == dcq_pkg::KIND_CLR_LOCAL)));
      stable       <= st;
      level        <= level_bits_next[s1_ch];
      new_change   <= nc;
      report_now   <= nc && immediate_mask[s1_ch];
      toggle_count <= upd.count;
      all_levels   <= level_bits_next;
      all_changed  <= local_bits_next;
    end
  end

  // Checks on the result logic and the stage handshake.
  a_report_needs_change: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!report_now || new_change))
    else $error("report_now without new_change");

  a_change_needs_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!new_change || (stable && handled)))
    else $error("new_change on an unqualified item");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |=> (s1_valid && $stable(s1_ch)))
    else $error("update stage lost an item under stall");

  a_ram_write_on_scan: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (s1_valid && (s1_kind == dcq_pkg::KIND_SCAN)))
    else $error("channel memory written by a non-scan item");

endmodule
